>>> rtl/core/pewr_pkg.sv
// ---------------------------------------------------------------------------
// pewr_pkg
// Shared types and codes for the process exit / wait reaper.
// ---------------------------------------------------------------------------
`default_nettype none

package pewr_pkg;

  localparam int SLOT_W = 5;
  localparam int CODE_W = 8;
  localparam int OP_W   = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_EXIT = 2'd0;
  localparam logic [OP_W-1:0] OP_WAIT = 2'd1;
  localparam logic [OP_W-1:0] OP_REG  = 2'd2;

  // report kinds
  localparam logic KIND_REAPED   = 1'b0;
  localparam logic KIND_NO_CHILD = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] caller_slot;
    logic [SLOT_W-1:0] parent_slot;
    logic [CODE_W-1:0] exit_code;
  } in_data_t;

  typedef struct packed {
    logic              report_kind;
    logic [SLOT_W-1:0] dest_slot;
    logic [SLOT_W-1:0] child_slot;
    logic [CODE_W-1:0] child_status;
    logic              last;
  } out_data_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARENT,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/process_exit_wait_reaper_core.sv
// Exit and wait: busy from the accepting edge through ST_FINISH, exit passing through
// ST_PARENT first; the scan reads one slot per cycle from the link/code memories.
// Register requests complete at the accepting edge; busy never rises for them.
// Reports leave through a one-cycle strobe (out_valid); the receiver cannot stall.
// Synchronous active-low reset clears all slot marks; link and code memories need none.
// ---------------------------------------------------------------------------
// process_exit_wait_reaper_core
// Process slot table with exit, wait and register requests; reaps hanging
// children and re-parents orphans to the init slot with one table scan.
// ---------------------------------------------------------------------------
`default_nettype none

module process_exit_wait_reaper_core #(
  parameter int NUM_SLOTS = 32,
  parameter int INIT_SLOT = 1
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  pewr_pkg::in_data_t   in_data,
  output logic                 out_valid,
  output pewr_pkg::out_data_t  out_data
);

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int LINK_W = ($clog2(INIT_SLOT + 1) > pewr_pkg::SLOT_W) ?
                          $clog2(INIT_SLOT + 1) : pewr_pkg::SLOT_W;
  localparam int CMP_W  = ((LINK_W > IDX_W) ? LINK_W : IDX_W) + 1;

  localparam logic [CMP_W-1:0]  NUM_CMP   = CMP_W'(NUM_SLOTS);
  localparam logic [IDX_W:0]    SCAN_END  = (IDX_W + 1)'(NUM_SLOTS);
  localparam bit                INIT_OK   = (INIT_SLOT < NUM_SLOTS);
  localparam logic [IDX_W-1:0]  INIT_IDX  = IDX_W'(INIT_SLOT % NUM_SLOTS);
  localparam logic [LINK_W-1:0] LINK_INIT = LINK_W'(INIT_SLOT);
  localparam logic [pewr_pkg::SLOT_W-1:0] DEST_INIT = pewr_pkg::SLOT_W'(INIT_SLOT);

  // slot table storage
  logic [LINK_W-1:0]           link_mem [NUM_SLOTS];
  logic [pewr_pkg::CODE_W-1:0] code_mem [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [NUM_SLOTS-1:0] waiting_r, waiting_nxt;
  logic [NUM_SLOTS-1:0] hanging_r, hanging_nxt;

  pewr_pkg::state_t    state_r, state_nxt;
  pewr_pkg::in_data_t  req_r, req_nxt;
  logic [IDX_W:0]      cnt_r, cnt_nxt;
  logic                d_vld_r, d_vld_nxt;
  logic [IDX_W-1:0]    d_idx_r, d_idx_nxt;
  logic                any_child_r, any_child_nxt;
  logic                found_r, found_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  pewr_pkg::out_data_t pend_r, pend_nxt;
  logic                out_vld_r, out_vld_nxt;
  pewr_pkg::out_data_t out_r, out_nxt;

  // memory ports
  logic [IDX_W-1:0]            rd_addr;
  logic [LINK_W-1:0]           link_q_r;
  logic [pewr_pkg::CODE_W-1:0] code_q_r;
  logic                        link_we;
  logic [IDX_W-1:0]            link_waddr;
  logic [LINK_W-1:0]           link_wdata;
  logic                        code_we;

  logic                new_vld;
  pewr_pkg::out_data_t new_rep;
  logic [IDX_W-1:0]    in_idx, me_idx, p_idx;
  logic                in_ok, p_wait, init_wait, issue_ok, match;

  assign in_idx    = IDX_W'(in_data.caller_slot);
  assign in_ok     = CMP_W'(in_data.caller_slot) < NUM_CMP;
  assign me_idx    = IDX_W'(req_r.caller_slot);
  assign p_idx     = IDX_W'(link_q_r);
  assign p_wait    = (CMP_W'(link_q_r) < NUM_CMP) && waiting_r[p_idx];
  assign init_wait = INIT_OK && waiting_r[INIT_IDX];
  assign issue_ok  = cnt_r < SCAN_END;
  assign match     = in_use_r[d_idx_r] && (link_q_r == LINK_W'(req_r.caller_slot));

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    d_vld_nxt     = 1'b0;
    d_idx_nxt     = d_idx_r;
    any_child_nxt = any_child_r;
    found_nxt     = found_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_vld_nxt   = 1'b0;
    out_nxt       = out_r;
    in_use_nxt    = in_use_r;
    waiting_nxt   = waiting_r;
    hanging_nxt   = hanging_r;
    rd_addr       = cnt_r[IDX_W-1:0];
    link_we       = 1'b0;
    link_waddr    = d_idx_r;
    link_wdata    = LINK_INIT;
    code_we       = 1'b0;
    new_vld       = 1'b0;
    new_rep       = '0;

    unique case (state_r)
      pewr_pkg::ST_IDLE: begin
        rd_addr       = in_idx;
        cnt_nxt       = '0;
        any_child_nxt = 1'b0;
        found_nxt     = 1'b0;
        pend_vld_nxt  = 1'b0;
        if (start && in_ok) begin
          req_nxt = in_data;
          if (in_data.opcode == pewr_pkg::OP_REG) begin
            link_we             = 1'b1;
            link_waddr          = in_idx;
            link_wdata          = LINK_W'(in_data.parent_slot);
            in_use_nxt[in_idx]  = 1'b1;
            waiting_nxt[in_idx] = 1'b0;
            hanging_nxt[in_idx] = 1'b0;
          end else if (in_use_r[in_idx]) begin
            if (in_data.opcode == pewr_pkg::OP_EXIT) begin
              state_nxt = pewr_pkg::ST_PARENT;
            end else if (in_data.opcode == pewr_pkg::OP_WAIT) begin
              state_nxt = pewr_pkg::ST_SCAN;
            end
          end
        end
      end

      pewr_pkg::ST_PARENT: begin
        // link_q_r holds the exiting slot's parent
        code_we = 1'b1;
        if (p_wait) begin
          waiting_nxt[p_idx]  = 1'b0;
          in_use_nxt[me_idx]  = 1'b0;
          waiting_nxt[me_idx] = 1'b0;
          hanging_nxt[me_idx] = 1'b0;
          new_vld              = 1'b1;
          new_rep.report_kind  = pewr_pkg::KIND_REAPED;
          new_rep.dest_slot    = link_q_r[pewr_pkg::SLOT_W-1:0];
          new_rep.child_slot   = req_r.caller_slot;
          new_rep.child_status = req_r.exit_code;
        end else begin
          hanging_nxt[me_idx] = 1'b1;
        end
        state_nxt = pewr_pkg::ST_SCAN;
      end

      pewr_pkg::ST_SCAN: begin
        // read slot cnt_r, evaluate slot d_idx_r from last cycle's read
        if (issue_ok) begin
          d_vld_nxt = 1'b1;
          d_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          state_nxt = pewr_pkg::ST_FINISH;
        end
        if (d_vld_r && match) begin
          if (req_r.opcode == pewr_pkg::OP_EXIT) begin
            link_we = 1'b1;
            if (init_wait && hanging_r[d_idx_r]) begin
              waiting_nxt[INIT_IDX] = 1'b0;
              in_use_nxt[d_idx_r]   = 1'b0;
              waiting_nxt[d_idx_r]  = 1'b0;
              hanging_nxt[d_idx_r]  = 1'b0;
              new_vld               = 1'b1;
              new_rep.report_kind   = pewr_pkg::KIND_REAPED;
              new_rep.dest_slot     = DEST_INIT;
              new_rep.child_slot    = pewr_pkg::SLOT_W'(d_idx_r);
              new_rep.child_status  = code_q_r;
            end
          end else if (!found_r) begin
            any_child_nxt = 1'b1;
            if (hanging_r[d_idx_r]) begin
              found_nxt             = 1'b1;
              in_use_nxt[d_idx_r]   = 1'b0;
              waiting_nxt[d_idx_r]  = 1'b0;
              hanging_nxt[d_idx_r]  = 1'b0;
              new_vld               = 1'b1;
              new_rep.report_kind   = pewr_pkg::KIND_REAPED;
              new_rep.dest_slot     = req_r.caller_slot;
              new_rep.child_slot    = pewr_pkg::SLOT_W'(d_idx_r);
              new_rep.child_status  = code_q_r;
            end
          end
        end
      end

      pewr_pkg::ST_FINISH: begin
        state_nxt    = pewr_pkg::ST_IDLE;
        pend_vld_nxt = 1'b0;
        if (pend_vld_r) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
        end else if (req_r.opcode == pewr_pkg::OP_WAIT) begin
          if (any_child_r) begin
            waiting_nxt[me_idx] = 1'b1;
          end else begin
            out_vld_nxt          = 1'b1;
            out_nxt.report_kind  = pewr_pkg::KIND_NO_CHILD;
            out_nxt.dest_slot    = req_r.caller_slot;
            out_nxt.child_slot   = '0;
            out_nxt.child_status = '0;
            out_nxt.last         = 1'b1;
          end
        end
      end

      default: state_nxt = pewr_pkg::ST_IDLE;
    endcase

    // hold each report until the next one shows whether it is the final one
    if (new_vld) begin
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = pend_r;
        out_nxt.last = 1'b0;
      end
      pend_vld_nxt = 1'b1;
      pend_nxt     = new_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pewr_pkg::ST_IDLE;
      in_use_r    <= '0;
      waiting_r   <= '0;
      hanging_r   <= '0;
      cnt_r       <= '0;
      d_vld_r     <= 1'b0;
      any_child_r <= 1'b0;
      found_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      waiting_r   <= waiting_nxt;
      hanging_r   <= hanging_nxt;
      cnt_r       <= cnt_nxt;
      d_vld_r     <= d_vld_nxt;
      any_child_r <= any_child_nxt;
      found_r     <= found_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    d_idx_r <= d_idx_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  // link and exit code memories: one write port each, shared registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[me_idx] <= req_r.exit_code;
    end
    code_q_r <= code_mem[rd_addr];
  end

  assign busy      = (state_r != pewr_pkg::ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
